// ===== rtl/pre_pkg.sv =====
// ----------------------------------------------------------------------------
// pre_pkg
// Shared types, constants and helpers of the printable run extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package pre_pkg;

  // Width of one stored character and of the length registers
  localparam int CHAR_W = 7;
  localparam int REG_W  = 6;

  // APB register map: two 32-bit registers at byte addresses 0 and 4
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // Reset values of the length registers
  localparam logic [REG_W-1:0] MIN_UNTERM_RST = REG_W'(6);
  localparam logic [REG_W-1:0] MIN_TERM_RST   = REG_W'(4);

  // Byte codes that end a run in the terminated sense
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;

  // Printable range
  localparam logic [7:0] CH_FIRST_PRINT = 8'h20;
  localparam logic [7:0] CH_LAST_PRINT  = 8'h7E;

  // Register index taken from paddr[2]
  typedef enum logic {
    REG_MIN_UNTERM = 1'b0,
    REG_MIN_TERM   = 1'b1
  } reg_idx_t;

  // Length thresholds handed from the register block to the sequencer
  typedef struct packed {
    logic [REG_W-1:0] min_unterm;
    logic [REG_W-1:0] min_term;
  } cfg_t;

  function automatic logic is_printable(input logic [7:0] c);
    return (c >= CH_FIRST_PRINT) && (c <= CH_LAST_PRINT);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pre_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pre_cfg_regs
// APB register block holding the two minimum run length thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module pre_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pre_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pre_pkg::DATA_W-1:0]    pwdata,
  output logic      [pre_pkg::DATA_W-1:0]    prdata,
  output pre_pkg::cfg_t                      cfg
);

  logic [pre_pkg::REG_W-1:0] min_unterm_r;
  logic [pre_pkg::REG_W-1:0] min_term_r;
  pre_pkg::reg_idx_t         reg_idx;
  logic                      wr_en;

  assign reg_idx = pre_pkg::reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;

  // Write the addressed register in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_unterm_r <= pre_pkg::MIN_UNTERM_RST;
      min_term_r   <= pre_pkg::MIN_TERM_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        pre_pkg::REG_MIN_UNTERM: min_unterm_r <= pwdata[pre_pkg::REG_W-1:0];
        pre_pkg::REG_MIN_TERM:   min_term_r   <= pwdata[pre_pkg::REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register, zero extended
  always_comb begin
    unique case (reg_idx)
      pre_pkg::REG_MIN_UNTERM:
        prdata = {{(pre_pkg::DATA_W-pre_pkg::REG_W){1'b0}}, min_unterm_r};
      pre_pkg::REG_MIN_TERM:
        prdata = {{(pre_pkg::DATA_W-pre_pkg::REG_W){1'b0}}, min_term_r};
      default:
        prdata = '0;
    endcase
  end

  assign cfg.min_unterm = min_unterm_r;
  assign cfg.min_term   = min_term_r;

endmodule

`default_nettype wire

// ===== rtl/pre_run_mem.sv =====
// ----------------------------------------------------------------------------
// pre_run_mem
// Run buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pre_run_mem #(
  parameter int DEPTH = 32
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr,
  input  wire logic [pre_pkg::CHAR_W-1:0]   wdata,
  input  wire logic                         re,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr,
  output logic      [pre_pkg::CHAR_W-1:0]   rdata
);

  logic [pre_pkg::CHAR_W-1:0] mem [DEPTH];

  // Store one character
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one character; hold the data while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/printable_run_extractor.sv =====
// ----------------------------------------------------------------------------
// printable_run_extractor
// Collects runs of printable bytes in a buffer memory and streams accepted
// runs out one character per request; a run ended by a non-printable byte
// is followed by the optional ending character and a line-end marker.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake               payload
//  in       sink       in_valid / in_stall     in_byte, in_new_file
//  out      source     out_valid / out_stall   out_char, out_line_end, out_last
//  cfg      APB slave  psel/penable/pready     paddr, pwdata, prdata
//
//  A byte that causes no result is taken without a stall. A byte that emits a
//  run of n > 0 characters is followed by t = 0, 1 or 2 tail results; read
//  data from the buffer is registered. An empty accepted run gives only its t
//  tail results. The single read port sets one character per cycle while
//  out_stall is low. Reset is synchronous; the run buffer is not cleared and
//  only entries of the current run are read. in_stall is high while a run drains.
//
`default_nettype none

module printable_run_extractor #(
  parameter int LINE_CHARS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input requests
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_new_file,
  // result requests
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pre_pkg::CHAR_W-1:0]    out_char,
  output logic                               out_line_end,
  output logic                               out_last,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pre_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [pre_pkg::DATA_W-1:0]    pwdata,
  output logic      [pre_pkg::DATA_W-1:0]    prdata,
  output logic                               pready
);

  localparam int CW    = $clog2(LINE_CHARS);
  localparam int CMP_W = pre_pkg::REG_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_TAIL
  } state_t;

  pre_pkg::cfg_t cfg;

  // Registers
  state_t                     state_r,      state_nxt;
  logic [CW-1:0]              count_r,      count_nxt;
  logic                       wrapped_r,    wrapped_nxt;
  logic [CW:0]                n_run_r,      n_run_nxt;
  logic [CW:0]                iss_r,        iss_nxt;
  logic [CW:0]                ld_r,         ld_nxt;
  logic                       pend_r,       pend_nxt;
  logic                       tail_r,       tail_nxt;
  logic                       chr_pend_r,   chr_pend_nxt;
  logic [pre_pkg::CHAR_W-1:0] chr_r,        chr_nxt;
  logic                       out_valid_r,  out_valid_nxt;
  logic [pre_pkg::CHAR_W-1:0] out_char_r,   out_char_nxt;
  logic                       out_le_r,     out_le_nxt;
  logic                       out_last_r,   out_last_nxt;

  // Memory port signals
  logic                       mem_we;
  logic                       mem_re;
  logic [pre_pkg::CHAR_W-1:0] mem_rdata;

  // Decode of the incoming byte
  logic [CW-1:0]              cnt_eff;
  logic                       wrap_eff;
  logic [CMP_W-1:0]           cnt_cmp;
  logic                       byte_print;
  logic                       byte_term;
  logic                       run_ok;
  logic                       out_free;
  logic                       ld_last;

  assign pready = 1'b1;

  pre_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // A write lands at the accepting edge; reads start in the cycle after it, so the
  // freshly written entry is already visible and no forwarding is needed.
  pre_run_mem #(
    .DEPTH (LINE_CHARS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_eff),
    .wdata (in_byte[pre_pkg::CHAR_W-1:0]),
    .re    (mem_re),
    .raddr (iss_r[CW-1:0]),
    .rdata (mem_rdata)
  );

  // Apply the new-file clear before the byte is looked at
  assign cnt_eff    = in_new_file ? '0 : count_r;
  assign wrap_eff   = in_new_file ? 1'b0 : wrapped_r;
  assign cnt_cmp    = {{(CMP_W-CW){1'b0}}, cnt_eff};
  assign byte_print = pre_pkg::is_printable(in_byte);
  assign byte_term  = (in_byte == pre_pkg::CH_NUL) || (in_byte == pre_pkg::CH_CR) ||
                      (in_byte == pre_pkg::CH_LF);
  assign run_ok     = wrap_eff ||
                      (cnt_cmp >= {1'b0, cfg.min_unterm}) ||
                      (byte_term && (cnt_cmp >= {1'b0, cfg.min_term}));

  assign out_free = !out_valid_r || !out_stall;
  assign ld_last  = (ld_r == n_run_r - 1'b1);

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    wrapped_nxt   = wrapped_r;
    n_run_nxt     = n_run_r;
    iss_nxt       = iss_r;
    ld_nxt        = ld_r;
    pend_nxt      = pend_r;
    tail_nxt      = tail_r;
    chr_pend_nxt  = chr_pend_r;
    chr_nxt       = chr_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_le_nxt    = out_le_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    // Drop a result that was taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          iss_nxt  = '0;
          ld_nxt   = '0;
          pend_nxt = 1'b0;
          if (byte_print) begin
            mem_we = 1'b1;
            if (cnt_eff == CW'(LINE_CHARS - 1)) begin
              // Buffer full: emit the whole run, no tail
              count_nxt   = '0;
              wrapped_nxt = 1'b1;
              n_run_nxt   = (CW+1)'(LINE_CHARS);
              tail_nxt    = 1'b0;
              state_nxt   = S_RUN;
            end else begin
              count_nxt   = cnt_eff + 1'b1;
              wrapped_nxt = wrap_eff;
            end
          end else begin
            count_nxt   = '0;
            wrapped_nxt = 1'b0;
            if (run_ok) begin
              n_run_nxt    = {1'b0, cnt_eff};
              tail_nxt     = 1'b1;
              chr_nxt      = in_byte[pre_pkg::CHAR_W-1:0];
              chr_pend_nxt = pre_pkg::is_printable({1'b0, in_byte[pre_pkg::CHAR_W-1:0]});
              state_nxt    = (cnt_eff == '0) ? S_TAIL : S_RUN;
            end
          end
        end
      end

      S_RUN: begin
        // Issue the next read when its data will have a place to go
        mem_re = (iss_r < n_run_r) && (!pend_r || out_free);
        if (mem_re) begin
          iss_nxt  = iss_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r && out_free) begin
          pend_nxt = 1'b0;
        end
        // Move read data into the output register
        if (pend_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = mem_rdata;
          out_le_nxt    = 1'b0;
          out_last_nxt  = ld_last && !tail_r;
          ld_nxt        = ld_r + 1'b1;
          if (ld_last) begin
            state_nxt = tail_r ? S_TAIL : S_IDLE;
          end
        end
      end

      S_TAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (chr_pend_r) begin
            out_char_nxt = chr_r;
            out_le_nxt   = 1'b0;
            out_last_nxt = 1'b0;
            chr_pend_nxt = 1'b0;
          end else begin
            out_char_nxt = '0;
            out_le_nxt   = 1'b1;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      wrapped_r   <= 1'b0;
      iss_r       <= '0;
      ld_r        <= '0;
      pend_r      <= 1'b0;
      tail_r      <= 1'b0;
      chr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wrapped_r   <= wrapped_nxt;
      iss_r       <= iss_nxt;
      ld_r        <= ld_nxt;
      pend_r      <= pend_nxt;
      tail_r      <= tail_nxt;
      chr_pend_r  <= chr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_run_r    <= n_run_nxt;
    chr_r      <= chr_nxt;
    out_char_r <= out_char_nxt;
    out_le_r   <= out_le_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_char     = out_char_r;
  assign out_line_end = out_le_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire
